/* sv/tsfm_pkg.sv */
package tsfm_pkg;
  localparam logic [1:0] FUNC_START  = 2'd0;
  localparam logic [1:0] FUNC_SAMPLE = 2'd1;
  localparam logic [1:0] FUNC_END    = 2'd2;

  localparam logic [2:0] REG_ROTATION  = 3'd0;
  localparam logic [2:0] REG_WIDTH     = 3'd1;
  localparam logic [2:0] REG_HEIGHT    = 3'd2;
  localparam logic [2:0] REG_X_LOW     = 3'd3;
  localparam logic [2:0] REG_X_HIGH    = 3'd4;
  localparam logic [2:0] REG_Y_LOW     = 3'd5;
  localparam logic [2:0] REG_Y_HIGH    = 3'd6;
  localparam logic [2:0] REG_THRESHOLD = 3'd7;

  localparam logic [11:0] Z2_LIMIT = 12'd4000;
  localparam int RAW_W = 12;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;
endpackage

/* sv/tsfm_sort_cell.sv */
module tsfm_sort_cell
  import tsfm_pkg::*;
(
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  logic [RAW_W-1:0] in_val,
  output logic [RAW_W-1:0] out_val,
  output logic [RAW_W-1:0] held
);
  logic [RAW_W-1:0] val;

  // Insertion cell: keeps the smaller value and passes the larger one on.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      val <= {RAW_W{1'b1}};
      out_val <= {RAW_W{1'b1}};
    end else if (ctrl.shift) begin
      if (in_val < val) begin
        val <= in_val;
        out_val <= val;
      end else begin
        out_val <= in_val;
      end
    end
  end

  assign held = val;
endmodule

/* sv/tsfm_sort_chain.sv */
module tsfm_sort_chain
  import tsfm_pkg::*;
#(
  parameter int N = 8
) (
  input  logic                 clk,
  input  cell_ctrl_t           ctrl,
  input  logic [RAW_W-1:0]     in_val,
  output logic [N*RAW_W-1:0]   sorted
);
  logic [RAW_W-1:0] link [N+1];

  assign link[0] = in_val;

  for (genvar i = 0; i < N; i++) begin : g_cell
    tsfm_sort_cell u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .in_val  (link[i]),
      .out_val (link[i+1]),
      .held    (sorted[i*RAW_W +: RAW_W])
    );
  end
endmodule

/* sv/tsfm_divider.sv */
module tsfm_divider (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  logic [23:0]        dividend,
  input  logic [12:0]        divisor,
  output logic               done,
  output logic [23:0]        quotient
);
  logic [4:0]  cnt;
  logic        run;
  logic [12:0] rem;
  logic [13:0] trial;

  assign trial = {rem, quotient[23]} - {1'b0, divisor};

  // Restoring division, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= 5'd0;
        rem <= '0;
        quotient <= dividend;
      end else if (run) begin
        if (!trial[13]) begin
          rem <= trial[12:0];
          quotient <= {quotient[22:0], 1'b1};
        end else begin
          rem <= {rem[11:0], quotient[23]};
          quotient <= {quotient[22:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'd23) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

/* sv/touch_sample_filter_and_map.sv */
// Channel   Ports                                     Direction
// command   start, busy, func, z_one, z_two,          in (busy: out)
//           x_sample, y_sample
// result    result_valid, touch_valid, screen_x,      out
//           screen_y
// config    psel, penable, pwrite, paddr, pwdata,     in/out
//           prdata, pready
// Start and sample transactions are taken in idle and leave busy low. An end
// transaction feeds each axis through the sorting cells and sums the middle
// half, then, if the touch is still valid, runs a serial division for each
// screen axis. busy is high while that work runs. rst clears the control
// state and sets the config registers to their defaults.
// The receiver cannot stall; result_valid is a one-cycle strobe.
module touch_sample_filter_and_map
  import tsfm_pkg::*;
#(
  parameter int SAMPLE_COUNT = 8,
  parameter int SPREAD_LIMIT = 64,
  parameter int RAW_FLOOR    = 100,
  parameter int RAW_CEILING  = 4000
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func,
  input  logic [11:0] z_one,
  input  logic [11:0] z_two,
  input  logic [11:0] x_sample,
  input  logic [11:0] y_sample,
  output logic        result_valid,
  output logic        touch_valid,
  output logic [10:0] screen_x,
  output logic [10:0] screen_y,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int CW       = $clog2(SAMPLE_COUNT + 2);
  localparam int IW       = $clog2(SAMPLE_COUNT);
  localparam int FW       = $clog2(2 * SAMPLE_COUNT);
  localparam int SKIP     = SAMPLE_COUNT / 4;
  localparam int KEEP     = SAMPLE_COUNT - 2 * SKIP;
  localparam int SW       = RAW_W + $clog2(KEEP + 1);
  localparam int FEEDS    = 2 * SAMPLE_COUNT - 2;
  localparam int MEAN_SH  = SW + $clog2(KEEP);
  localparam int MEAN_MUL = (2 ** MEAN_SH + KEEP - 1) / KEEP;
  localparam int MW       = 2 * SW + 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOAD  = 4'd1;
  localparam logic [3:0] S_FEED  = 4'd2;
  localparam logic [3:0] S_SUM   = 4'd3;
  localparam logic [3:0] S_MEAN  = 4'd4;
  localparam logic [3:0] S_MAPA  = 4'd5;
  localparam logic [3:0] S_MUL   = 4'd6;
  localparam logic [3:0] S_DIVW  = 4'd7;
  localparam logic [3:0] S_CLAMP = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [1:0]  rotation;
  logic [11:0] screen_width, screen_height;
  logic [11:0] raw_x_low, raw_x_high, raw_y_low, raw_y_high;
  logic [11:0] press_threshold;
  logic        cfg_wr;
  logic [2:0]  reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation <= 2'd0;
      screen_width <= 12'd320;
      screen_height <= 12'd240;
      raw_x_low <= 12'd0;
      raw_x_high <= 12'd4095;
      raw_y_low <= 12'd0;
      raw_y_high <= 12'd4095;
      press_threshold <= 12'd100;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_ROTATION:  rotation <= pwdata[1:0];
        REG_WIDTH:     screen_width <= pwdata[11:0];
        REG_HEIGHT:    screen_height <= pwdata[11:0];
        REG_X_LOW:     raw_x_low <= pwdata[11:0];
        REG_X_HIGH:    raw_x_high <= pwdata[11:0];
        REG_Y_LOW:     raw_y_low <= pwdata[11:0];
        REG_Y_HIGH:    raw_y_high <= pwdata[11:0];
        REG_THRESHOLD: press_threshold <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_ROTATION:  prdata[1:0] = rotation;
      REG_WIDTH:     prdata[11:0] = screen_width;
      REG_HEIGHT:    prdata[11:0] = screen_height;
      REG_X_LOW:     prdata[11:0] = raw_x_low;
      REG_X_HIGH:    prdata[11:0] = raw_x_high;
      REG_Y_LOW:     prdata[11:0] = raw_y_low;
      REG_Y_HIGH:    prdata[11:0] = raw_y_high;
      REG_THRESHOLD: prdata[11:0] = press_threshold;
      default: ;
    endcase
  end

  // Sample stores; registers read at an index that walks in order.
  logic [RAW_W-1:0] x_store [SAMPLE_COUNT];
  logic [RAW_W-1:0] y_store [SAMPLE_COUNT];
  logic [CW-1:0]    sample_count;
  logic             start_ok;
  logic [3:0]       state;
  logic             axis;
  logic [FW-1:0]    feed_cnt;
  logic             ok;
  logic [SW-1:0]    sum;
  logic [11:0]      ax, ay;
  logic [CW-1:0]    sum_idx;
  logic             accept;
  logic [MW-1:0]    mean_prod;
  logic [11:0]      mean;

  assign busy   = state != S_IDLE;
  assign accept = start && !busy;

  // The mean of the middle half is a multiplication by the rounded-up reciprocal.
  assign mean_prod = MW'(sum) * MW'(MEAN_MUL);
  assign mean      = 12'(mean_prod >> MEAN_SH);

  cell_ctrl_t       ctrl;
  logic [RAW_W-1:0] feed_val;
  logic [SAMPLE_COUNT*RAW_W-1:0] sorted;

  assign ctrl.load  = state == S_LOAD;
  assign ctrl.shift = state == S_FEED;
  always_comb begin
    feed_val = {RAW_W{1'b1}};
    if (feed_cnt < FW'(SAMPLE_COUNT))
      feed_val = axis ? y_store[feed_cnt[IW-1:0]] : x_store[feed_cnt[IW-1:0]];
  end

  tsfm_sort_chain #(.N(SAMPLE_COUNT)) u_chain (
    .clk    (clk),
    .ctrl   (ctrl),
    .in_val (feed_val),
    .sorted (sorted)
  );

  logic [RAW_W-1:0] lo_val, hi_val, sum_val;
  assign lo_val  = sorted[SKIP*RAW_W +: RAW_W];
  assign hi_val  = sorted[(SAMPLE_COUNT-SKIP-1)*RAW_W +: RAW_W];
  assign sum_val = sorted[sum_idx[IW-1:0]*RAW_W +: RAW_W];

  // Mapping datapath.
  logic        map_axis;
  logic [11:0] m_raw, m_lo, m_hi, m_size;
  logic        m_inv;
  logic [11:0] top;
  logic signed [12:0] span, delta;
  logic [12:0] abs_span;
  logic        neg;
  logic [23:0] prod;
  logic        div_go, div_done;
  logic [23:0] quotient;
  logic [10:0] sx;
  logic        swap, inv_x, inv_y;
  logic signed [13:0] sval;

  assign swap  = !rotation[0];
  assign inv_x = rotation <= 2'd1;
  assign inv_y = rotation == 2'd0 || rotation == 2'd3;

  always_comb begin
    if (map_axis == 1'b0) begin
      m_raw  = swap ? ay : ax;
      m_lo   = swap ? raw_y_low : raw_x_low;
      m_hi   = swap ? raw_y_high : raw_x_high;
      m_size = screen_width;
      m_inv  = inv_x;
    end else begin
      m_raw  = swap ? ax : ay;
      m_lo   = swap ? raw_x_low : raw_y_low;
      m_hi   = swap ? raw_x_high : raw_y_high;
      m_size = screen_height;
      m_inv  = inv_y;
    end
    if (m_size == 12'd0) top = 12'd0;
    else if (m_size > 12'd2048) top = 12'd2047;
    else top = m_size - 12'd1;
  end

  tsfm_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (prod),
    .divisor  (abs_span),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    sval = neg ? -$signed({2'b00, quotient[11:0]}) : $signed({2'b00, quotient[11:0]});
    if (quotient[23:12] != '0) sval = neg ? -14'sd4096 : 14'sd4095;
    if (m_inv) sval = $signed({2'b00, top}) - sval;
    if (sval < 0) sval = '0;
    if (sval > $signed({2'b00, top})) sval = $signed({2'b00, top});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sample_count <= '0;
      start_ok <= 1'b0;
      result_valid <= 1'b0;
      div_go <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      div_go <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (func)
              FUNC_START: begin
                start_ok <= z_one != 12'd0 && z_two <= Z2_LIMIT && z_one > press_threshold;
                sample_count <= '0;
              end
              FUNC_SAMPLE: begin
                if (sample_count < CW'(SAMPLE_COUNT)) begin
                  x_store[sample_count[IW-1:0]] <= x_sample;
                  y_store[sample_count[IW-1:0]] <= y_sample;
                  sample_count <= sample_count + 1'b1;
                end else begin
                  sample_count <= CW'(SAMPLE_COUNT + 1);
                end
              end
              FUNC_END: begin
                ok <= start_ok && sample_count == CW'(SAMPLE_COUNT) && z_one > press_threshold;
                start_ok <= 1'b0;
                sample_count <= '0;
                axis <= 1'b0;
                state <= S_LOAD;
              end
              default: ;
            endcase
          end
        end
        S_LOAD: begin
          feed_cnt <= '0;
          state <= S_FEED;
        end
        S_FEED: begin
          feed_cnt <= feed_cnt + 1'b1;
          if (feed_cnt == FW'(FEEDS)) begin
            sum <= '0;
            sum_idx <= CW'(SKIP);
            state <= S_SUM;
          end
        end
        S_SUM: begin
          if (hi_val - lo_val > RAW_W'(SPREAD_LIMIT)) ok <= 1'b0;
          sum <= sum + SW'(sum_val);
          sum_idx <= sum_idx + 1'b1;
          if (sum_idx == CW'(SAMPLE_COUNT - SKIP - 1)) state <= S_MEAN;
        end
        S_MEAN: begin
          if (axis) ay <= mean;
          else      ax <= mean;
          if (mean < 12'(RAW_FLOOR) || mean > 12'(RAW_CEILING)) ok <= 1'b0;
          if (!axis) begin
            axis <= 1'b1;
            state <= S_LOAD;
          end else begin
            map_axis <= 1'b0;
            state <= ok ? S_MAPA : S_OUT;
          end
        end
        S_MAPA: begin
          span <= $signed({1'b0, m_hi}) - $signed({1'b0, m_lo});
          delta <= $signed({1'b0, m_raw}) - $signed({1'b0, m_lo});
          if (m_hi == m_lo) begin
            ok <= 1'b0;
            state <= S_OUT;
          end else begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          abs_span <= span[12] ? 13'(-span) : 13'(span);
          prod <= 24'(delta[12] ? 13'(-delta) : 13'(delta)) * 24'(top);
          neg <= delta[12] ^ span[12];
          state <= S_DIVW;
          div_go <= 1'b1;
        end
        S_DIVW: begin
          if (div_done) state <= S_CLAMP;
        end
        S_CLAMP: begin
          if (!map_axis) begin
            sx <= 11'(sval);
            map_axis <= 1'b1;
            state <= S_MAPA;
          end else begin
            screen_y <= 11'(sval);
            screen_x <= sx;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          result_valid <= 1'b1;
          touch_valid <= ok;
          if (!ok) begin
            screen_x <= '0;
            screen_y <= '0;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
